// File: rtl/core/first_fit_hole_allocator_unit_macros.svh
// Assertion macros for the first-fit hole allocator
`ifndef FIRST_FIT_HOLE_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_HOLE_ALLOCATOR_UNIT_MACROS_SVH

// Check that a condition implies a consequence at the same edge
`define FFH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that a condition implies a consequence at the next edge
`define FFH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/ffha_pkg.sv
// Shared types and constants for the first-fit hole allocator
package ffha_pkg;
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_ZERO  = 2'd3;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [15:0] req_start;
    logic [15:0] req_size;
  } ffha_in_t;

  typedef struct packed {
    logic [15:0] alloc_address;
    logic [1:0]  status;
  } ffha_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic init;     // reload table with one hole (none when total_memory is zero)
    logic load;     // capture request, clear scan index
    logic step;     // advance scan index
    logic back;     // back scan index up one, stopping at zero
    logic alloc;    // apply allocate at scan index
    logic insert;   // insert free hole at scan index
    logic merge;    // merge at scan index
    logic shl;      // remove entry (shift left) at index, or at index+1 with merge, over whole table
  } ffha_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic size_zero;
    logic at_end;     // index >= count
    logic full;       // count == max
    logic fits;       // length[idx] >= size
    logic empties;    // length[idx] == size
    logic below;      // start[idx] < req_start
    logic adjacent;   // idx+1 < count and idx adjacent to idx+1
    logic last_pair;  // idx+1 >= count
  } ffha_sts_t;
endpackage

// File: rtl/core/ffha_datapath.sv
// Hole table registers and per-step arithmetic
module ffha_datapath import ffha_pkg::*; #(
  parameter int MAX_HOLES = 16,
  parameter int ADDR_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ffha_cmd_t cmd,
  input  logic [15:0] total_memory,
  input  ffha_in_t  req,
  output ffha_sts_t sts,
  output logic [15:0] hit_start
);
  localparam int IW = $clog2(MAX_HOLES);
  localparam int CW = $clog2(MAX_HOLES + 1);
  localparam logic [ADDR_BITS-1:0] AMAX = {ADDR_BITS{1'b1}};

  logic [ADDR_BITS-1:0] start_r [MAX_HOLES];
  logic [ADDR_BITS-1:0] len_r   [MAX_HOLES];
  logic [ADDR_BITS-1:0] start_nxt [MAX_HOLES];
  logic [ADDR_BITS-1:0] len_nxt   [MAX_HOLES];
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [ADDR_BITS-1:0] rs_r, rz_r, rs_nxt, rz_nxt;
  logic [ADDR_BITS-1:0] tm;
  logic [ADDR_BITS-1:0] cs, cl, ns, nl;
  logic [IW-1:0] ix, ix1;
  logic [ADDR_BITS:0] endp, sum;

  assign tm = ADDR_BITS'(total_memory);
  assign ix = idx_r[IW-1:0];
  assign ix1 = IW'(idx_r + CW'(1));
  assign cs = start_r[ix];
  assign cl = len_r[ix];
  assign ns = start_r[ix1];
  assign nl = len_r[ix1];
  assign endp = {1'b0, cs} + {1'b0, cl};
  assign sum = {1'b0, cl} + {1'b0, nl};

  // Report scan conditions
  always_comb begin
    sts.size_zero = (rz_r == '0);
    sts.at_end    = (idx_r >= count_r);
    sts.full      = (count_r == CW'(MAX_HOLES));
    sts.fits      = (cl >= rz_r);
    sts.empties   = (cl == rz_r);
    sts.below     = (cs < rs_r);
    sts.last_pair = ((idx_r + CW'(1)) >= count_r);
    sts.adjacent  = !sts.last_pair && (endp == {1'b0, ns});
  end
  assign hit_start = 16'(cs);

  // Update table
  always_comb begin
    start_nxt = start_r;
    len_nxt   = len_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    rs_nxt    = rs_r;
    rz_nxt    = rz_r;
    if (cmd.init) begin
      for (int i = 0; i < MAX_HOLES; i++) begin
        start_nxt[i] = '0;
        len_nxt[i]   = '0;
      end
      len_nxt[0] = tm;
      count_nxt  = (tm != '0) ? CW'(1) : '0;
    end
    if (cmd.load) begin
      rs_nxt  = ADDR_BITS'(req.req_start);
      rz_nxt  = ADDR_BITS'(req.req_size);
      idx_nxt = '0;
    end
    if (cmd.step) idx_nxt = idx_r + CW'(1);
    // Start the merge pass at the hole before the inserted one
    if (cmd.back && idx_r != '0) idx_nxt = idx_r - CW'(1);
    if (cmd.alloc) begin
      start_nxt[ix] = cs + rz_r;
      len_nxt[ix]   = cl - rz_r;
    end
    if (cmd.merge) len_nxt[ix] = sum[ADDR_BITS] ? AMAX : sum[ADDR_BITS-1:0];
    // Remove entry at position p (= ix for shl on alloc uses idx, merge uses ix1)
    if (cmd.shl) begin
      for (int i = 0; i < MAX_HOLES - 1; i++) begin
        if (CW'(i) >= (cmd.merge ? idx_r + CW'(1) : idx_r)) begin
          start_nxt[i] = start_r[i+1];
          len_nxt[i]   = len_r[i+1];
        end
      end
      if (cmd.merge) len_nxt[ix] = sum[ADDR_BITS] ? AMAX : sum[ADDR_BITS-1:0];
      start_nxt[MAX_HOLES-1] = '0;
      len_nxt[MAX_HOLES-1]   = '0;
      count_nxt = count_r - CW'(1);
    end
    if (cmd.insert) begin
      for (int i = 1; i < MAX_HOLES; i++) begin
        if (CW'(i) > idx_r) begin
          start_nxt[i] = start_r[i-1];
          len_nxt[i]   = len_r[i-1];
        end
      end
      start_nxt[ix] = rs_r;
      len_nxt[ix]   = rz_r;
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CW'(1);
      idx_r   <= '0;
      for (int i = 0; i < MAX_HOLES; i++) begin
        start_r[i] <= '0;
        len_r[i]   <= (i == 0) ? AMAX & ADDR_BITS'(16'hFFFF) : '0;
      end
    end else begin
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rs_r <= rs_nxt;
    rz_r <= rz_nxt;
  end
endmodule

// File: rtl/core/ffha_ctrl.sv
// Request sequencer for the hole table
module ffha_ctrl import ffha_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      req_free,
  input  logic      cfg_we,
  input  ffha_sts_t sts,
  input  logic [15:0] hit_start,
  output ffha_cmd_t cmd,
  output logic      back,
  output logic      busy,
  output logic      done,
  output ffha_out_t res
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_ASCAN = 3'd2;
  localparam logic [2:0] S_FSCAN = 3'd3;
  localparam logic [2:0] S_BACK  = 3'd4;
  localparam logic [2:0] S_MERGE = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic free_r, free_nxt;
  ffha_out_t res_r, res_nxt;

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_DONE);
  assign back = (state_r == S_BACK);
  assign res  = res_r;

  // Sequence one request
  always_comb begin
    state_nxt = state_r;
    free_nxt  = free_r;
    res_nxt   = res_r;
    cmd       = '0;
    cmd.init  = cfg_we;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          free_nxt  = req_free;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        res_nxt = '{alloc_address: 16'd0, status: ST_OK};
        priority if (sts.size_zero) begin
          res_nxt.status = ST_ZERO;
          state_nxt = S_DONE;
        end else if (!free_r) begin
          state_nxt = S_ASCAN;
        end else if (sts.full) begin
          res_nxt.status = ST_FULL;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_FSCAN;
        end
      end
      S_ASCAN: begin
        priority if (sts.at_end) begin
          res_nxt.status = ST_NOFIT;
          state_nxt = S_DONE;
        end else if (sts.fits) begin
          res_nxt.alloc_address = hit_start;
          cmd.alloc = 1'b1;
          cmd.shl   = sts.empties;
          state_nxt = S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_FSCAN: begin
        if (!sts.at_end && sts.below) cmd.step = 1'b1;
        else begin
          cmd.insert = 1'b1;
          state_nxt  = S_BACK;
        end
      end
      S_BACK: begin
        // Start merging from the hole before the new one
        state_nxt = S_MERGE;
      end
      S_MERGE: begin
        priority if (sts.last_pair) state_nxt = S_DONE;
        else if (sts.adjacent) begin
          cmd.merge = 1'b1;
          cmd.shl   = 1'b1;
        end else cmd.step = 1'b1;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      free_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      free_r  <= free_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end
endmodule

// File: rtl/core/ffha_back.sv
// Index back-off helper: one position before the inserted hole
module ffha_back import ffha_pkg::*; (
  input  logic      in_back,
  input  ffha_cmd_t cmd_in,
  output ffha_cmd_t cmd_out
);
  // Request a decrement of the scan index when entering the merge pass
  always_comb begin
    cmd_out      = cmd_in;
    cmd_out.back = in_back;
  end
endmodule

// File: rtl/core/first_fit_hole_allocator_unit.sv
// First-fit hole allocator top level
// An allocate scans the hole table from the first hole until a hole fits or
// the table ends; a free scans for its insert position and then runs a merge
// pass from the hole before the inserted one (or the first hole), one entry
// per cycle. A size of zero, or a free into a full table, answers straight
// from the dispatch state.
// busy stays high until the result beat, which is shown for one cycle on
// out_valid and cannot be stalled. A total_memory write reloads the table
// and is taken only while idle.
`include "first_fit_hole_allocator_unit_macros.svh"
module first_fit_hole_allocator_unit import ffha_pkg::*; #(
  parameter int MAX_HOLES = 16,
  parameter int ADDR_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  ffha_in_t  in_req,
  output logic      out_valid,
  output ffha_out_t out_res,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [15:0] cfg_total_memory
);
  ffha_cmd_t cmd, cmd_c;
  ffha_sts_t sts;
  logic [15:0] hit_start;
  logic back, cfg_we;

  assign cfg_ready = !busy;
  assign cfg_we = cfg_valid && cfg_ready;

  ffha_ctrl u_ctrl (
    .clk, .rst_n, .start, .req_free(in_req.req_type == REQ_FREE), .cfg_we,
    .sts, .hit_start, .cmd(cmd_c), .back, .busy, .done(out_valid), .res(out_res)
  );

  ffha_back u_back (.in_back(back), .cmd_in(cmd_c), .cmd_out(cmd));

  ffha_datapath #(.MAX_HOLES(MAX_HOLES), .ADDR_BITS(ADDR_BITS)) u_dp (
    .clk, .rst_n, .cmd, .total_memory(cfg_total_memory), .req(in_req),
    .sts, .hit_start
  );

  `FFH_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
  `FFH_ASSERT_NEXT(a_done_idle, clk, rst_n, out_valid, !busy)
  `FFH_ASSERT_IMPL(a_fail_zero, clk, rst_n, out_valid && out_res.status != ST_OK,
    out_res.alloc_address == 16'd0)
endmodule
